@@ design/tdps_pkg.sv @@
`default_nettype none

package tdps_pkg;

   // Datapath width of the shared multiply/divide unit. Every product and
   // quotient of the search fits: the largest is (P+1)*T, below 2^45 for any
   // reload width and search radius in range.
   localparam int DW = 48;

   // Clock register width and its reset value.
   localparam int CLK_W = 30;
   localparam logic [CLK_W-1:0] CLK_RESET = CLK_W'(36000000);

   // Result status codes.
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_ZERO  = 2'd1,
      ST_ABOVE = 2'd2
   } status_type;

   // Operations of the shared arithmetic unit.
   typedef enum logic {
      OP_MUL = 1'b0,
      OP_DIV = 1'b1
   } op_type;

endpackage

`default_nettype wire

@@ design/tdps_muldiv.sv @@
`default_nettype none

module tdps_muldiv
   import tdps_pkg::*;
#(
   parameter int WIDTH = 48
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire op_type           op,
   input  wire logic [WIDTH-1:0] opa,
   input  wire logic [WIDTH-1:0] opb,
   output logic                  done,
   output logic      [WIDTH-1:0] result
);

   localparam int CW = $clog2(WIDTH + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   op_type           op_ff, op_in;
   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] sh_ff, sh_in;
   logic [WIDTH-1:0] mb_ff, mb_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [WIDTH:0]   trial;

   // One bit per cycle: shift-add multiply or restoring divide.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      acc_in  = acc_ff;
      sh_in   = sh_ff;
      mb_in   = mb_ff;
      cnt_in  = cnt_ff;
      trial   = {acc_ff, sh_ff[WIDTH-1]};
      if (start) begin
         busy_in = 1'b1;
         op_in   = op;
         acc_in  = '0;
         sh_in   = opa;
         mb_in   = opb;
         cnt_in  = '0;
      end else if (busy_ff) begin
         unique case (op_ff)
            OP_MUL: begin
               if (mb_ff[0]) begin
                  acc_in = acc_ff + sh_ff;
               end
               sh_in = {sh_ff[WIDTH-2:0], 1'b0};
               mb_in = {1'b0, mb_ff[WIDTH-1:1]};
            end
            OP_DIV: begin
               if (trial >= {1'b0, mb_ff}) begin
                  acc_in = WIDTH'(trial - {1'b0, mb_ff});
                  sh_in  = {sh_ff[WIDTH-2:0], 1'b1};
               end else begin
                  acc_in = trial[WIDTH-1:0];
                  sh_in  = {sh_ff[WIDTH-2:0], 1'b0};
               end
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff  <= op_in;
      acc_ff <= acc_in;
      sh_ff  <= sh_in;
      mb_ff  <= mb_in;
      cnt_ff <= cnt_in;
   end

   assign done   = done_ff;
   assign result = (op_ff == OP_MUL) ? acc_ff : sh_ff;

endmodule

`default_nettype wire

@@ design/timer_divider_pair_search_unit.sv @@
`default_nettype none

// Timer prescaler and reload search. A beat on req_ carries a target
// frequency in unsigned Q24.8 Hz; the block answers with one rsp_ beat that
// holds the prescaler and reload pair whose truncated Q.8 frequency
// 256*clk/((P+1)(A+1)) is closest to the target, over at most 2*SEARCH_RADIUS+1
// prescalers around the first estimate. A zero target or a target above the
// clock is answered at once, with rsp_valid up in the cycle after the beat.
// Any other target runs through one shared multiply/divide unit that resolves
// one bit per cycle. The first estimate needs five operations and every
// candidate four. The block takes no new beat while a search runs. The user
// must write the clock register through csr_wr_en and csr_wr_data only while
// the block is idle; the block itself does not enforce this.
module timer_divider_pair_search_unit
   import tdps_pkg::*;
#(
   parameter int RELOAD_BITS   = 16,
   parameter int SEARCH_RADIUS = 20
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [31:0]      req_target_freq,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic      [23:0]      rsp_prescaler,
   output logic      [15:0]      rsp_reload,
   output logic      [37:0]      rsp_achieved_freq,
   output logic      [1:0]       rsp_status,
   input  wire logic             csr_wr_en,
   input  wire logic [CLK_W-1:0] csr_wr_data
);

   localparam logic [DW-1:0] SPAN   = DW'(1) << RELOAD_BITS;
   localparam logic [DW-1:0] AMAX   = SPAN - DW'(1);
   localparam logic [DW-1:0] RADIUS = DW'(SEARCH_RADIUS);

   typedef enum logic [3:0] {
      S_IDLE, S_QDIV, S_A0MUL, S_A0DIV, S_MUL1, S_DIV1, S_MUL2, S_DIV2, S_DONE
   } state_type;

   state_type        state_ff;
   logic [CLK_W-1:0] clk_ff;
   logic             start_ff;
   op_type           op_ff;
   logic [DW-1:0]    opa_ff, opb_ff;
   logic [DW-1:0]    t_ff, n_ff, p_ff, lo_ff, phi_ff, pc_ff;
   logic [DW-1:0]    pb_ff, ab_ff, eb_ff, achb_ff;
   logic             init_ff;
   logic             rsp_valid_ff;
   logic [23:0]      psc_ff;
   logic [15:0]      rld_ff;
   logic [37:0]      ach_ff;
   status_type       status_ff;

   logic             mu_done;
   logic [DW-1:0]    mu_result;
   logic [DW-1:0]    n_req, t_req;
   logic [DW-1:0]    p0, q_round, r_dec, a_clamp, err, p_next;
   logic             out_free;
   logic             rsp_load;

   tdps_muldiv #(.WIDTH(DW)) u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .start  (start_ff),
      .op     (op_ff),
      .opa    (opa_ff),
      .opb    (opb_ff),
      .done   (mu_done),
      .result (mu_result)
   );

   // Helper values derived from the unit's result, the request and the state.
   always_comb begin
      n_req   = DW'({clk_ff, 8'h00});
      t_req   = DW'(req_target_freq);
      q_round = mu_result + SPAN - DW'(1);
      p0      = (q_round >> RELOAD_BITS) - DW'(1);
      r_dec   = (mu_result == '0) ? '0 : mu_result - DW'(1);
      a_clamp = (r_dec > AMAX) ? AMAX : r_dec;
      err     = (mu_result > t_ff) ? mu_result - t_ff : t_ff - mu_result;
      p_next  = p_ff + DW'(1);
      out_free = !rsp_valid_ff || rsp_ready;
   end

   assign req_ready = (state_ff == S_IDLE) && out_free;

   // A result beat is loaded on an early answer or at the end of a search.
   assign rsp_load = ((state_ff == S_IDLE) && req_valid && req_ready &&
                      ((t_req == '0) || (t_req > n_req))) ||
                     ((state_ff == S_DONE) && out_free);

   // Clock register.
   always_ff @(posedge clock) begin
      if (reset) begin
         clk_ff <= CLK_RESET;
      end else if (csr_wr_en) begin
         clk_ff <= csr_wr_data;
      end
   end

   // Sequencer: issues one operation at a time to the shared unit.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff <= 1'b0;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid && req_ready) begin
                  t_ff <= t_req;
                  n_ff <= n_req;
                  if (t_req == '0) begin
                     psc_ff       <= '0;
                     rld_ff       <= '0;
                     ach_ff       <= '0;
                     status_ff    <= ST_ZERO;
                  end else if (t_req > n_req) begin
                     psc_ff       <= '0;
                     rld_ff       <= '0;
                     ach_ff       <= n_req[37:0];
                     status_ff    <= ST_ABOVE;
                  end else begin
                     op_ff    <= OP_DIV;
                     opa_ff   <= n_req + t_req - DW'(1);
                     opb_ff   <= t_req;
                     start_ff <= 1'b1;
                     state_ff <= S_QDIV;
                  end
               end
            end
            S_QDIV: begin
               if (mu_done) begin
                  p_ff     <= p0;
                  lo_ff    <= (p0 > RADIUS) ? p0 - RADIUS : '0;
                  phi_ff   <= p0 + RADIUS;
                  op_ff    <= OP_MUL;
                  opa_ff   <= p0 + DW'(1);
                  opb_ff   <= t_ff;
                  start_ff <= 1'b1;
                  state_ff <= S_A0MUL;
               end
            end
            S_A0MUL, S_MUL2: begin
               if (mu_done) begin
                  op_ff    <= OP_DIV;
                  opa_ff   <= n_ff;
                  opb_ff   <= mu_result;
                  start_ff <= 1'b1;
                  state_ff <= (state_ff == S_A0MUL) ? S_A0DIV : S_DIV2;
               end
            end
            S_A0DIV, S_DIV1: begin
               // Both give a reload candidate one above the value to use.
               if (mu_done) begin
                  pc_ff    <= a_clamp;
                  init_ff  <= (state_ff == S_A0DIV);
                  op_ff    <= OP_MUL;
                  opa_ff   <= p_ff + DW'(1);
                  opb_ff   <= a_clamp + DW'(1);
                  start_ff <= 1'b1;
                  state_ff <= S_MUL2;
               end
            end
            S_MUL1: begin
               if (mu_done) begin
                  op_ff    <= OP_DIV;
                  opa_ff   <= (n_ff << 1) + mu_result;
                  opb_ff   <= mu_result << 1;
                  start_ff <= 1'b1;
                  state_ff <= S_DIV1;
               end
            end
            S_DIV2: begin
               if (mu_done) begin
                  if (init_ff || (err < eb_ff)) begin
                     pb_ff   <= p_ff;
                     ab_ff   <= pc_ff;
                     eb_ff   <= err;
                     achb_ff <= mu_result;
                  end
                  if (init_ff) begin
                     p_ff     <= lo_ff;
                     op_ff    <= OP_MUL;
                     opa_ff   <= lo_ff + DW'(1);
                     opb_ff   <= t_ff;
                     start_ff <= 1'b1;
                     state_ff <= S_MUL1;
                  end else if (p_ff == phi_ff) begin
                     state_ff <= S_DONE;
                  end else begin
                     p_ff     <= p_next;
                     op_ff    <= OP_MUL;
                     opa_ff   <= p_next + DW'(1);
                     opb_ff   <= t_ff;
                     start_ff <= 1'b1;
                     state_ff <= S_MUL1;
                  end
               end
            end
            S_DONE: begin
               if (out_free) begin
                  psc_ff       <= pb_ff[23:0];
                  rld_ff       <= ab_ff[15:0];
                  ach_ff       <= achb_ff[37:0];
                  status_ff    <= ST_OK;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_prescaler     = psc_ff;
   assign rsp_reload        = rld_ff;
   assign rsp_achieved_freq = ach_ff;
   assign rsp_status        = status_ff;

endmodule

`default_nettype wire
